### hdl/llc_pkg.sv
// Package for the LRU lookup cache: stream widths, request codes, slot and cell control types.
// Has no dependencies. The cell, the top level and the checker import it.
`timescale 1ns / 1ps

package llc_pkg;

  localparam int LLC_ENTRIES  = 8;
  localparam int LLC_KEY_BITS = 32;

  localparam int WORD_W      = 32;
  localparam int IN_TDATA_W  = 3 * WORD_W;
  localparam int OUT_TDATA_W = 4 * WORD_W;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // One slot of the cache. The key is kept beside it because its width is a parameter.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] table_id;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] uses;
  } entry_t;

  // Control that the sequencer sends to every cell of the row.
  typedef struct packed {
    logic capture;    // register the tag compare
    logic shift_all;  // insert: the whole row moves back by one
    logic shift_hit;  // lookup hit: cells up to the first match move back
  } cell_ctl_t;

endpackage

### hdl/llc_cell.sv
// One cell of the recency-ordered row: holds a slot, compares its tag, and shifts from its neighbor.
// Depends on llc_pkg.
`timescale 1ns / 1ps

module llc_cell #(
  parameter int KEY_BITS = llc_pkg::LLC_KEY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  llc_pkg::cell_ctl_t              ctl,
  input  logic [llc_pkg::WORD_W-1:0]      req_table,
  input  logic [KEY_BITS-1:0]             req_key,
  input  llc_pkg::entry_t                 prev_ent,
  input  logic [KEY_BITS-1:0]             prev_key,
  input  logic                            above_in,
  output llc_pkg::entry_t                 ent,
  output logic [KEY_BITS-1:0]             key,
  output logic                            match,
  output logic                            above_out
);
  import llc_pkg::*;

  entry_t              ent_r;
  logic [KEY_BITS-1:0] key_r;
  logic                match_r;
  logic                shift;

  // On a hit only the cells ahead of and at the first match move.
  assign shift = ctl.shift_all | (ctl.shift_hit & ~above_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
      match_r     <= 1'b0;
    end else begin
      if (shift) begin
        ent_r <= prev_ent;
        key_r <= prev_key;
      end
      if (ctl.capture) begin
        match_r <= ent_r.valid && (ent_r.table_id == req_table) && (key_r == req_key);
      end
    end
  end

  assign ent       = ent_r;
  assign key       = key_r;
  assign match     = match_r;
  assign above_out = above_in | match_r;

endmodule

### hdl/lru_lookup_cache_unit.sv
// Top level of the LRU lookup cache: request register, sequencer, row of cells, result register.
// Depends on llc_pkg and llc_cell.
//
//  channel | direction | tdata (low bit first)                       | tuser
//  in_     | slave     | table_id, key_id, entry_value               | req_type
//  out_    | master    | found_value, use_count, hit_total, miss_total | hit
//
// Each transaction has two steps: S_CMP registers the tag compare in every cell,
// S_UPD shifts the row into move-to-front order and loads the result register.
// A new request is taken in the same cycle the previous one finishes, but not before,
// so requests do not overlap. A result waiting in the output register
// stalls the update cycle of the next request. Reset empties every slot; no clearing pass.
`timescale 1ns / 1ps

module lru_lookup_cache_unit #(
  parameter int ENTRIES  = llc_pkg::LLC_ENTRIES,
  parameter int KEY_BITS = llc_pkg::LLC_KEY_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [llc_pkg::IN_TDATA_W-1:0]     in_tdata,   // table_id, key_id, entry_value
  input  logic                               in_tuser,   // req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [llc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // found_value, use_count,
                                                         // hit_total, miss_total
  output logic                               out_tuser   // hit
);
  import llc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic                req_type_r;
  logic [WORD_W-1:0]   table_r;
  logic [KEY_BITS-1:0] key_r;
  logic [WORD_W-1:0]   value_r;
  logic [63:0]         key_wide;

  logic                out_valid_r;
  logic                out_hit_r;
  logic [WORD_W-1:0]   out_found_r;
  logic [WORD_W-1:0]   out_uses_r;
  logic [WORD_W-1:0]   hit_cnt_r, hit_cnt_nxt;
  logic [WORD_W-1:0]   miss_cnt_r, miss_cnt_nxt;

  logic                in_fire;
  logic                upd_fire;
  logic                is_insert;
  logic                hit_any;

  cell_ctl_t           ctl;
  entry_t              ent   [ENTRIES];
  logic [KEY_BITS-1:0] keys  [ENTRIES];
  logic [ENTRIES-1:0]  match;
  logic [ENTRIES:0]    above;
  entry_t              head_ent;
  logic [WORD_W-1:0]   sel_value;
  logic [WORD_W-1:0]   sel_uses;
  logic [WORD_W-1:0]   sel_uses_inc;

  assign key_wide  = {32'd0, in_tdata[2*WORD_W-1:WORD_W]};
  assign is_insert = (req_type_r == REQ_INSERT);

  assign upd_fire  = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == S_IDLE) || upd_fire;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_fire) state_nxt = in_fire ? S_CMP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign ctl.capture   = (state_r == S_CMP);
  assign ctl.shift_all = upd_fire && is_insert;
  assign ctl.shift_hit = upd_fire && !is_insert && hit_any;

  assign above[0] = 1'b0;
  assign hit_any  = above[ENTRIES];

  // The most recent match is the first cell with no match ahead of it.
  always_comb begin
    sel_value = '0;
    sel_uses  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i] && !above[i]) begin
        sel_value = sel_value | ent[i].value;
        sel_uses  = sel_uses | ent[i].uses;
      end
    end
  end

  assign sel_uses_inc = sel_uses + WORD_W'(1);

  always_comb begin
    head_ent.valid    = 1'b1;
    head_ent.table_id = table_r;
    head_ent.value    = is_insert ? value_r : sel_value;
    head_ent.uses     = is_insert ? WORD_W'(1) : sel_uses_inc;
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        llc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctl       (ctl),
          .req_table (table_r),
          .req_key   (key_r),
          .prev_ent  (head_ent),
          .prev_key  (key_r),
          .above_in  (above[g]),
          .ent       (ent[g]),
          .key       (keys[g]),
          .match     (match[g]),
          .above_out (above[g+1])
        );
      end else begin : g_body
        llc_cell #(.KEY_BITS(KEY_BITS)) u_cell (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctl       (ctl),
          .req_table (table_r),
          .req_key   (key_r),
          .prev_ent  (ent[g-1]),
          .prev_key  (keys[g-1]),
          .above_in  (above[g]),
          .ent       (ent[g]),
          .key       (keys[g]),
          .match     (match[g]),
          .above_out (above[g+1])
        );
      end
    end
  endgenerate

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (!is_insert) begin
      if (hit_any) hit_cnt_nxt  = hit_cnt_r + WORD_W'(1);
      else         miss_cnt_nxt = miss_cnt_r + WORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        req_type_r <= in_tuser;
        table_r    <= in_tdata[WORD_W-1:0];
        key_r      <= key_wide[KEY_BITS-1:0];
        value_r    <= in_tdata[3*WORD_W-1:2*WORD_W];
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= miss_cnt_nxt;
        out_hit_r   <= !is_insert && hit_any;
        out_found_r <= (!is_insert && hit_any) ? sel_value : '0;
        if (is_insert)    out_uses_r <= WORD_W'(1);
        else if (hit_any) out_uses_r <= sel_uses_inc;
        else              out_uses_r <= '0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {miss_cnt_r, hit_cnt_r, out_uses_r, out_found_r};

endmodule

### hdl/llc_checker.sv
// Port-level checks for the LRU lookup cache, bound to the top level.
// Depends on llc_pkg and lru_lookup_cache_unit.
`timescale 1ns / 1ps

module llc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [llc_pkg::OUT_TDATA_W-1:0] out_tdata,  // found_value, use_count,
                                                     // hit_total, miss_total
  input logic                            out_tuser   // hit
);
  import llc_pkg::*;

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The compare cycle follows every accepted request, so no request can follow at once.
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted in the compare cycle");

  // Misses and inserts never return a value.
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[WORD_W-1:0] == '0)
    else $error("value returned without a hit");

  // Without a hit the use count is zero for a miss or one for an insert.
  a_miss_uses: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[2*WORD_W-1:WORD_W] == WORD_W'(0) || out_tdata[2*WORD_W-1:WORD_W] == WORD_W'(1))
    else $error("bad use count without a hit");

endmodule

bind lru_lookup_cache_unit llc_checker u_llc_checker (.*);
